// File: hdl/frs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg: shared types and helpers for the feedback record parser
// Parse phase codes, result status codes, the parser-to-summary record
// struct and the decimal digit helpers.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int unsigned NumW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam logic [NumW-1:0] NumMax       = 16'hFFFF;
  localparam logic [NumW-1:0] CeilingReset = 16'd9999;

  localparam logic [ByteW-1:0] ChR     = 8'h52;  // 'R'
  localparam logic [ByteW-1:0] ChW     = 8'h57;  // 'W'
  localparam logic [ByteW-1:0] ChComma = 8'h2C;  // ','
  localparam logic [ByteW-1:0] Ch0     = 8'h30;  // '0'
  localparam logic [ByteW-1:0] Ch9     = 8'h39;  // '9'
  localparam logic [ByteW-1:0] ChNul   = 8'h00;

  localparam logic KindByte  = 1'b0;
  localparam logic KindClear = 1'b1;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_TAG    = 6'b000010,
    PH_FIRST  = 6'b000100,
    PH_SECOND = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_REJECT = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_REJECT = 2'd1,
    ST_CLEAR  = 2'd2
  } status_e;

  // Outcome of one byte as seen by the summary logic
  typedef struct packed {
    logic            record_ok;
    logic [NumW-1:0] first;
    logic [NumW-1:0] second;
  } parse_res_t;

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= Ch0) && (c <= Ch9);
  endfunction

  // acc * 10 + digit, saturated to the number width
  function automatic logic [NumW-1:0] add_digit(input logic [NumW-1:0]  acc,
                                                input logic [ByteW-1:0] c);
    logic [NumW+3:0] prod;
    logic [NumW+3:0] sum;
    begin
      prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
      sum  = prod + {{(NumW-4){1'b0}}, c - Ch0};
      if (sum > {4'b0000, NumMax}) begin
        return NumMax;
      end
      return sum[NumW-1:0];
    end
  endfunction

endpackage

// File: hdl/frs_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_parser: per-byte record parser
// Tracks the tag search and the two decimal fields of one payload, and
// reports whether the payload holds an accepted record at its last byte.
// ----------------------------------------------------------------------------
module frs_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [frs_pkg::ByteW-1:0] char_byte_i,
  input  logic                      last_byte_i,
  output frs_pkg::parse_res_t       res_o
);
  import frs_pkg::*;

  phase_e          phase_q, phase_d, phase_t;
  logic [NumW-1:0] first_q, first_d, first_t;
  logic [NumW-1:0] second_q, second_d, second_t;
  logic            seen_q, seen_d, seen_t;
  logic            is_tag;
  logic            is_dig;

  assign is_tag = (char_byte_i == ChR) || (char_byte_i == ChW);
  assign is_dig = is_digit(char_byte_i);

  // Take one byte
  always_comb begin
    phase_t  = phase_q;
    first_t  = first_q;
    second_t = second_q;
    seen_t   = seen_q;
    case (phase_q)
      PH_SEARCH: begin
        if (char_byte_i == ChNul) phase_t = PH_REJECT;
        else if (is_tag)          phase_t = PH_TAG;
      end
      PH_TAG: begin
        if (char_byte_i == ChNul) begin
          phase_t = PH_REJECT;
        end else if (char_byte_i == ChComma) begin
          phase_t = PH_FIRST;
          seen_t  = 1'b0;
        end else if (!is_tag) begin
          phase_t = PH_SEARCH;
        end
      end
      PH_FIRST: begin
        if (is_dig) begin
          first_t = add_digit(first_q, char_byte_i);
          seen_t  = 1'b1;
        end else if (seen_q && (char_byte_i == ChComma)) begin
          phase_t = PH_SECOND;
          seen_t  = 1'b0;
        end else begin
          phase_t = PH_REJECT;
        end
      end
      PH_SECOND: begin
        if (is_dig) begin
          second_t = add_digit(second_q, char_byte_i);
          seen_t   = 1'b1;
        end else begin
          phase_t = seen_q ? PH_DONE : PH_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.record_ok = (phase_t == PH_DONE) || ((phase_t == PH_SECOND) && seen_t);
  assign res_o.first     = first_t;
  assign res_o.second    = second_t;

  // Return to the search state after every final byte
  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    seen_d   = seen_q;
    if (step_i) begin
      if (last_byte_i) begin
        phase_d  = PH_SEARCH;
        first_d  = '0;
        second_d = '0;
        seen_d   = 1'b0;
      end else begin
        phase_d  = phase_t;
        first_d  = first_t;
        second_d = second_t;
        seen_d   = seen_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      first_q  <= '0;
      second_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      seen_q   <= seen_d;
    end
  end

endmodule

// File: hdl/frs_summary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_summary: sweep summary keeper
// Keeps the nearest nonzero distance and the saturating obstacle count,
// and forms the status and values of each result.
// ----------------------------------------------------------------------------
module frs_summary (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     kind_i,
  input  logic                     last_byte_i,
  input  frs_pkg::parse_res_t      res_i,
  input  logic [frs_pkg::NumW-1:0] ceiling_i,
  output frs_pkg::status_e         status_o,
  output logic [frs_pkg::NumW-1:0] nearest_o,
  output logic [frs_pkg::NumW-1:0] total_o
);
  import frs_pkg::*;

  logic [NumW-1:0] nearest_q, nearest_d;
  logic [NumW-1:0] count_q, count_d;
  logic [NumW:0]   sum;
  logic [NumW-1:0] nearest_upd;
  logic [NumW-1:0] count_upd;

  // Merge an accepted record
  assign sum = {1'b0, count_q} + {1'b0, res_i.second};
  assign count_upd = (sum > {1'b0, ceiling_i}) ? ceiling_i : sum[NumW-1:0];
  assign nearest_upd = ((res_i.first != '0) &&
                        ((nearest_q == '0) || (res_i.first < nearest_q))) ?
                       res_i.first : nearest_q;

  always_comb begin
    nearest_d = nearest_q;
    count_d   = count_q;
    status_o  = ST_REJECT;
    if (kind_i == KindClear) begin
      nearest_d = '0;
      count_d   = '0;
      status_o  = ST_CLEAR;
    end else if (res_i.record_ok) begin
      nearest_d = nearest_upd;
      count_d   = count_upd;
      status_o  = ST_ACCEPT;
    end
  end

  assign nearest_o = nearest_d;
  assign total_o   = count_d;

  // Commit only at a payload end or clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nearest_q <= '0;
      count_q   <= '0;
    end else if (step_i && ((kind_i == KindClear) || last_byte_i)) begin
      nearest_q <= nearest_d;
      count_q   <= count_d;
    end
  end

endmodule

// File: hdl/feedback_record_parser_summary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_record_parser_summary: text record parser with sweep summary
// Registers each byte, parses it in one pass against the kept state and
// registers the result of each payload end or clear transaction.
// ----------------------------------------------------------------------------
// Path: an accepted transaction is held in the input register, then its result
//   is written to the result register once the result register has room.
// Throughput: one transaction per cycle while the result side does not stall,
//   set by the combinational parse and merge pass between the two registers.
// Reset: asynchronous, active low; parser returns to tag search, kept
//   distance and count clear, ceiling returns to 9999.
module feedback_record_parser_summary (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [frs_pkg::ByteW-1:0] char_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [frs_pkg::NumW-1:0]  nearest_distance_o,
  output logic [frs_pkg::NumW-1:0]  obstacle_total_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [frs_pkg::NumW-1:0]  cfg_data_i
);
  import frs_pkg::*;

  logic             in_valid_q;
  logic             kind_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic [NumW-1:0]  ceiling_q;
  logic             out_valid_q;
  status_e          status_q;
  logic [NumW-1:0]  nearest_q;
  logic [NumW-1:0]  total_q;

  logic             has_result;
  logic             out_free;
  logic             advance;
  parse_res_t       parse_res;
  status_e          status_d;
  logic [NumW-1:0]  nearest_d;
  logic [NumW-1:0]  total_d;

  // Pipeline control: move the held transaction when its result has room
  assign has_result = (kind_q == KindClear) || last_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!has_result || out_free);
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      kind_q <= kind_i;
      byte_q <= char_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Ceiling register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CeilingReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ceiling_q <= cfg_data_i;
    end
  end

  frs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance && (kind_q == KindByte)),
    .char_byte_i (byte_q),
    .last_byte_i (last_q),
    .res_o       (parse_res)
  );

  frs_summary u_summary (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .kind_i      (kind_q),
    .last_byte_i (last_q),
    .res_i       (parse_res),
    .ceiling_i   (ceiling_q),
    .status_o    (status_d),
    .nearest_o   (nearest_d),
    .total_o     (total_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      status_q  <= status_d;
      nearest_q <= nearest_d;
      total_q   <= total_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign nearest_distance_o = nearest_q;
  assign obstacle_total_o   = total_q;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && has_result && out_valid_q && out_stall_i) |-> !advance)
    else $error("result register overwritten while stalled");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_CLEAR)) |-> ((nearest_q == '0) && (total_q == '0)))
    else $error("clear result carries nonzero summary");

  a_quiet_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(advance && has_result)) |=> !out_valid_q)
    else $error("result appeared without a finishing transaction");

endmodule

// File: sim/frs_summary_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_summary_checker: result predictor and scoreboard for the record parser
// Watches the byte, result and ceiling channels, tracks the parse state and
// the kept sweep summary on its own, and compares every result transaction
// field by field against the oldest predicted summary.
// ----------------------------------------------------------------------------
module frs_summary_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      kind_i,
  input  logic [frs_pkg::ByteW-1:0] char_byte_i,
  input  logic                      last_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [1:0]                status_i,
  input  logic [frs_pkg::NumW-1:0]  nearest_distance_i,
  input  logic [frs_pkg::NumW-1:0]  obstacle_total_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [frs_pkg::NumW-1:0]  cfg_data_i,
  output int unsigned               error_count_o,
  output int unsigned               pending_o
);
  import frs_pkg::*;

  typedef struct packed {
    status_e         status;
    logic [NumW-1:0] nearest;
    logic [NumW-1:0] total;
  } summary_t;

  summary_t        expected_summary_q[$];
  int unsigned     mismatch_count = 0;

  // Parser state and kept sweep summary
  phase_e          scan_phase     = PH_SEARCH;
  logic [NumW-1:0] dist_acc       = '0;
  logic [NumW-1:0] count_acc      = '0;
  logic            have_digit     = 1'b0;
  logic [NumW-1:0] nearest_kept   = '0;
  logic [NumW-1:0] total_kept     = '0;
  logic [NumW-1:0] total_ceiling  = CeilingReset;

  assign error_count_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Append one decimal digit, clamp at the number ceiling
  function automatic logic [NumW-1:0] decimal_append(input logic [NumW-1:0]  acc,
                                                     input logic [ByteW-1:0] c);
    logic [NumW+3:0] wide;
    wide = {4'b0000, acc} * 20'd10 + {12'b0, c - Ch0};
    return (wide > {4'b0000, NumMax}) ? NumMax : wide[NumW-1:0];
  endfunction

  // Advance the parser by one transaction; queue a summary on payload end or clear
  task automatic predict_summary(input logic kind, input logic [ByteW-1:0] c,
                                 input logic last);
    summary_t        res;
    logic            digit;
    logic            tag;
    logic [NumW:0]   sum;
    if (kind == KindClear) begin
      nearest_kept = '0;
      total_kept   = '0;
      res = '{ST_CLEAR, '0, '0};
      expected_summary_q.push_back(res);
      return;
    end
    digit = (c >= Ch0) && (c <= Ch9);
    tag   = (c == ChR) || (c == ChW);
    case (scan_phase)
      PH_SEARCH: begin
        if (c == ChNul) scan_phase = PH_REJECT;
        else if (tag) scan_phase = PH_TAG;
      end
      PH_TAG: begin
        if (c == ChNul) begin
          scan_phase = PH_REJECT;
        end else if (c == ChComma) begin
          scan_phase = PH_FIRST;
          have_digit = 1'b0;
        end else if (!tag) begin
          scan_phase = PH_SEARCH;
        end
      end
      PH_FIRST: begin
        if (digit) begin
          dist_acc   = decimal_append(dist_acc, c);
          have_digit = 1'b1;
        end else if (have_digit && c == ChComma) begin
          scan_phase = PH_SECOND;
          have_digit = 1'b0;
        end else begin
          scan_phase = PH_REJECT;
        end
      end
      PH_SECOND: begin
        if (digit) begin
          count_acc  = decimal_append(count_acc, c);
          have_digit = 1'b1;
        end else begin
          scan_phase = have_digit ? PH_DONE : PH_REJECT;
        end
      end
      default: ;
    endcase
    if (!last) return;
    if (scan_phase == PH_DONE || (scan_phase == PH_SECOND && have_digit)) begin
      if (dist_acc != '0 && (nearest_kept == '0 || dist_acc < nearest_kept))
        nearest_kept = dist_acc;
      sum = {1'b0, total_kept} + {1'b0, count_acc};
      total_kept = (sum > {1'b0, total_ceiling}) ? total_ceiling : sum[NumW-1:0];
      res.status = ST_ACCEPT;
    end else begin
      res.status = ST_REJECT;
    end
    res.nearest = nearest_kept;
    res.total   = total_kept;
    expected_summary_q.push_back(res);
    scan_phase = PH_SEARCH;
    dist_acc   = '0;
    count_acc  = '0;
    have_digit = 1'b0;
  endtask

  // Check results before predicting, so a same-edge input never satisfies them
  always @(posedge clk_i or negedge rst_ni) begin
    summary_t want;
    if (!rst_ni) begin
      expected_summary_q.delete();
      scan_phase    = PH_SEARCH;
      dist_acc      = '0;
      count_acc     = '0;
      have_digit    = 1'b0;
      nearest_kept  = '0;
      total_kept    = '0;
      total_ceiling = CeilingReset;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_summary_q.size() == 0) begin
          report_mismatch("result with nothing pending, status", status_i, 0);
        end else begin
          want = expected_summary_q.pop_front();
          if (status_i != want.status)
            report_mismatch("status", status_i, want.status);
          if (nearest_distance_i != want.nearest)
            report_mismatch("nearest_distance", nearest_distance_i, want.nearest);
          if (obstacle_total_i != want.total)
            report_mismatch("obstacle_total", obstacle_total_i, want.total);
        end
      end
      if (cfg_valid_i && cfg_ready_i) total_ceiling = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_summary(kind_i, char_byte_i, last_byte_i);
      pending_o <= expected_summary_q.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for feedback_record_parser_summary
// Drives directed and random text payloads and clear transactions under
// several ceiling settings and idling mixes, including a long result hold-off
// that backs up the input; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
module tb;
  import frs_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseItems    = 190;
  localparam int unsigned PhaseCount    = 6;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             kind_i;
  logic [ByteW-1:0] char_byte_i;
  logic             last_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       status_o;
  logic [NumW-1:0]  nearest_distance_o;
  logic [NumW-1:0]  obstacle_total_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [NumW-1:0]  cfg_data_i;

  int unsigned      error_count;
  int unsigned      pending_count;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_req       = 0;
  int unsigned      item_count     = 0;
  int unsigned      idle_cycles    = 0;
  logic [ByteW-1:0] payload_q[$];

  feedback_record_parser_summary DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .char_byte_i        (char_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .nearest_distance_o (nearest_distance_o),
    .obstacle_total_o   (obstacle_total_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  frs_summary_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .kind_i             (kind_i),
    .char_byte_i        (char_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .nearest_distance_i (nearest_distance_o),
    .obstacle_total_i   (obstacle_total_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .error_count_o      (error_count),
    .pending_o          (pending_count)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // End the run when no channel has moved a transaction for too long
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  // Offer one transaction after a random gap; return once it is accepted
  task automatic send_item(input logic kind, input logic [ByteW-1:0] c,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    char_byte_i <= c;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_count++;
  endtask

  // Send the queued payload, now and then slipping a clear in between bytes
  task automatic send_payload();
    for (int i = 0; i < payload_q.size(); i++) begin
      if ($urandom_range(99) < 3)
        send_item(KindClear, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
      send_item(KindByte, payload_q[i], i == payload_q.size() - 1);
    end
    payload_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) payload_q.push_back(s[i]);
  endtask

  // Mostly short numbers, a few long enough to saturate
  task automatic push_number();
    int unsigned nd;
    nd = ($urandom_range(99) < 6) ? $urandom_range(6, 7) : $urandom_range(1, 4);
    repeat (nd) payload_q.push_back(ByteW'(Ch0 + $urandom_range(9)));
  endtask

  task automatic push_junk(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(5))
        0: payload_q.push_back(($urandom_range(1)) ? ChR : ChW);
        1: payload_q.push_back(ChComma);
        2: payload_q.push_back(ByteW'(Ch0 + $urandom_range(9)));
        3: payload_q.push_back(ChNul);
        default: payload_q.push_back(ByteW'($urandom_range(255)));
      endcase
    end
  endtask

  // One random transaction group: clear, well-formed record, or noise
  task automatic send_random_payload();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      send_item(KindClear, ByteW'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (sel < 80) begin
      repeat ($urandom_range(0, 2)) payload_q.push_back(ByteW'($urandom_range(1, 255)));
      if ($urandom_range(9) == 0) payload_q.push_back(($urandom_range(1)) ? ChR : ChW);
      payload_q.push_back(($urandom_range(1)) ? ChR : ChW);
      payload_q.push_back(ChComma);
      push_number();
      payload_q.push_back(ChComma);
      if ($urandom_range(19) != 0) push_number();
      case ($urandom_range(3))
        0: begin
          payload_q.push_back(ChNul);
          push_junk($urandom_range(2));
        end
        1: push_junk($urandom_range(1, 3));
        default: ;
      endcase
      send_payload();
    end else begin
      push_junk($urandom_range(1, 8));
      send_payload();
    end
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ceiling(input logic [NumW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    logic [NumW-1:0] ceiling;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    kind_i      <= KindByte;
    char_byte_i <= '0;
    last_byte_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Repeated tag: the second tag starts the record
    push_text("RW,7,3");
    send_payload();
    // Clear during a record, saturated count hits the reset ceiling, NUL ends text
    send_item(KindByte, ChW, 1'b0);
    send_item(KindByte, ChComma, 1'b0);
    send_item(KindClear, 8'hFF, 1'b1);
    push_text("0,70000");
    payload_q.push_back(ChNul);
    send_payload();
    // NUL before the tag rejects, later bytes ignored
    payload_q.push_back(ChNul);
    payload_q.push_back(8'hFF);
    send_payload();
    // NUL after the comma with an empty second number rejects
    push_text("R,5,");
    payload_q.push_back(ChNul);
    send_payload();
    wait_quiet();

    // Random phases over ceiling settings and idling mixes
    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      case (p)
        0: ceiling = '0;
        1: ceiling = NumMax;
        2: ceiling = 16'd150;
        3: ceiling = 16'd20;
        4: ceiling = NumW'($urandom_range(65535));
        default: ceiling = CeilingReset;
      endcase
      write_ceiling(ceiling);
      // Back up the results so the input channel stalls
      if (p == 0) hold_req = HoldOffCycles;
      for (int unsigned stop = item_count + PhaseItems; item_count < stop; )
        send_random_payload();
      wait_quiet();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
